@@ rtl/vcg_pkg.sv @@
// Shared types, codes and lookup tables for the velocity curve generator.
`default_nettype none

package vcg_pkg;

   // Points per request and the index of the last one.
   localparam int POINT_COUNT = 17;
   localparam logic [4:0] LAST_POINT = 5'(POINT_COUNT - 1);
   // The subito shape switches from start to end at this point.
   localparam logic [4:0] HALF_POINT = 5'd8;

   // Lowest and highest legal velocity.
   localparam logic signed [9:0] VEL_MIN = 10'sd1;
   localparam logic signed [9:0] VEL_MAX = 10'sd127;

   // Fixed velocities for the forte-piano accent, the forte-piano body and the sforzando.
   localparam logic [6:0] VEL_FP_HIGH = 7'd96;
   localparam logic [6:0] VEL_FP_LOW  = 7'd49;
   localparam logic [6:0] VEL_SFZ     = 7'd127;

   // Curve shape codes.
   typedef enum logic [3:0] {
      SHAPE_CONSTANT   = 4'd0,
      SHAPE_CRESC      = 4'd1,
      SHAPE_DECRESC    = 4'd2,
      SHAPE_SWELL      = 4'd3,
      SHAPE_HAIRPIN    = 4'd4,
      SHAPE_SFZ        = 4'd5,
      SHAPE_FORTEPIANO = 4'd6,
      SHAPE_TERRACED   = 4'd7,
      SHAPE_SUBITO     = 4'd8
   } shape_type;

   // Annotation codes carried by each point.
   typedef enum logic [2:0] {
      NOTE_NONE   = 3'd0,
      NOTE_CRESC  = 3'd1,
      NOTE_DIM    = 3'd2,
      NOTE_SFZ    = 3'd3,
      NOTE_FP     = 3'd4,
      NOTE_SUBITO = 3'd5
   } note_type;

   // One request item.
   typedef struct packed {
      logic [3:0]  curve_shape;
      logic [2:0]  start_level;
      logic [2:0]  end_level;
      logic [23:0] span_ticks;
   } req_type;

   // One curve point item.
   typedef struct packed {
      logic [4:0]  point_number;
      logic [23:0] point_tick;
      logic [6:0]  point_velocity;
      logic [2:0]  point_level;
      logic [2:0]  point_note;
      logic        last_point;
   } rsp_type;

   // Velocity of each dynamic marking, ppp through fff.
   function automatic logic [6:0] level_vel(input logic [2:0] level);
      logic [6:0] v;
      unique case (level)
         3'd0: v = 7'd16;
         3'd1: v = 7'd33;
         3'd2: v = 7'd49;
         3'd3: v = 7'd64;
         3'd4: v = 7'd80;
         3'd5: v = 7'd96;
         3'd6: v = 7'd112;
         default: v = 7'd127;
      endcase
      return v;
   endfunction

   // Half sine over the curve in unsigned Q1.16.
   function automatic logic [16:0] sine_q16(input logic [4:0] idx);
      logic [16:0] s;
      unique case (idx)
         5'd1, 5'd15:  s = 17'd12785;
         5'd2, 5'd14:  s = 17'd25080;
         5'd3, 5'd13:  s = 17'd36410;
         5'd4, 5'd12:  s = 17'd46341;
         5'd5, 5'd11:  s = 17'd54491;
         5'd6, 5'd10:  s = 17'd60547;
         5'd7, 5'd9:   s = 17'd64277;
         5'd8:         s = 17'd65536;
         default:      s = 17'd0;
      endcase
      return s;
   endfunction

   // Marking recovered from a clamped velocity.
   function automatic logic [2:0] vel_to_level(input logic [6:0] v);
      logic [2:0] lv;
      priority if (v < 7'd25)  lv = 3'd0;
      else if (v < 7'd41)      lv = 3'd1;
      else if (v < 7'd57)      lv = 3'd2;
      else if (v < 7'd72)      lv = 3'd3;
      else if (v < 7'd88)      lv = 3'd4;
      else if (v < 7'd104)     lv = 3'd5;
      else if (v < 7'd120)     lv = 3'd6;
      else                     lv = 3'd7;
      return lv;
   endfunction

endpackage

`default_nettype wire

@@ rtl/vcg_point.sv @@
// Combinational evaluation of one curve point from a held request and a point index.
`default_nettype none

module vcg_point
   import vcg_pkg::*;
(
   input  var req_type    req,
   input  var logic [4:0] idx,
   output rsp_type        point
);

   // Signed k*d divided by 2**sh, truncated toward zero.
   function automatic logic signed [9:0] mul_div(input logic [16:0] k,
                                                 input logic signed [7:0] d,
                                                 input logic [4:0] sh);
      logic signed [25:0] p;
      logic signed [25:0] bias;
      logic signed [25:0] q;
      p    = $signed({1'b0, k}) * d;
      bias = p[25] ? $signed((26'd1 << sh) - 26'd1) : 26'sd0;
      q    = (p + bias) >>> sh;
      return q[9:0];
   endfunction

   logic [6:0]         sv;
   logic [6:0]         ev;
   logic signed [7:0]  d;
   logic signed [9:0]  sv_s;
   logic signed [9:0]  ev_s;
   logic [16:0]        idx_k;
   logic signed [9:0]  vel_raw;
   logic [6:0]         vel;
   note_type           note;
   logic [19:0]        tstep;
   logic [24:0]        tick_full;

   // Marking velocities and their difference.
   assign sv    = level_vel(req.start_level);
   assign ev    = level_vel(req.end_level);
   assign sv_s  = $signed({3'b000, sv});
   assign ev_s  = $signed({3'b000, ev});
   assign d     = $signed({1'b0, ev}) - $signed({1'b0, sv});
   assign idx_k = {12'd0, idx};

   // Shape rule for the raw velocity and the annotation.
   always_comb begin
      vel_raw = sv_s;
      note    = NOTE_NONE;
      unique case (req.curve_shape)
         SHAPE_CRESC: begin
            vel_raw = sv_s + mul_div(idx_k, d, 5'd4);
            if (idx == 5'd0) note = NOTE_CRESC;
         end
         SHAPE_DECRESC: begin
            vel_raw = sv_s - mul_div(idx_k, -d, 5'd4);
            if (idx == 5'd0) note = NOTE_DIM;
         end
         SHAPE_SWELL: begin
            if (idx < HALF_POINT) vel_raw = sv_s + mul_div(idx_k, d, 5'd3);
            else vel_raw = ev_s - mul_div(idx_k - 17'd8, d, 5'd3);
         end
         SHAPE_HAIRPIN: begin
            vel_raw = sv_s + mul_div(sine_q16(idx), d, 5'd16);
         end
         SHAPE_SFZ: begin
            vel_raw = (idx <= 5'd1) ? $signed({3'b000, VEL_SFZ}) : sv_s;
            if (idx == 5'd0) note = NOTE_SFZ;
         end
         SHAPE_FORTEPIANO: begin
            vel_raw = (idx <= 5'd1) ? $signed({3'b000, VEL_FP_HIGH})
                                    : $signed({3'b000, VEL_FP_LOW});
            if (idx == 5'd0) note = NOTE_FP;
         end
         SHAPE_TERRACED: begin
            vel_raw = sv_s + mul_div({14'd0, idx[4:2]}, d, 5'd2);
         end
         SHAPE_SUBITO: begin
            vel_raw = (idx < HALF_POINT) ? sv_s : ev_s;
            if (idx == HALF_POINT) note = NOTE_SUBITO;
         end
         default: begin
            vel_raw = sv_s;
         end
      endcase
   end

   // Clamp into the legal velocity range.
   always_comb begin
      priority if (vel_raw < VEL_MIN) vel = VEL_MIN[6:0];
      else if (vel_raw > VEL_MAX)     vel = VEL_MAX[6:0];
      else                            vel = vel_raw[6:0];
   end

   // Tick position is the index times a sixteenth of the span.
   assign tstep     = req.span_ticks[23:4];
   assign tick_full = {5'd0, tstep} * {20'd0, idx};

   always_comb begin
      point.point_number   = idx;
      point.point_tick     = tick_full[23:0];
      point.point_velocity = vel;
      point.point_level    = vel_to_level(vel);
      point.point_note     = note;
      point.last_point     = (idx == LAST_POINT);
   end

endmodule

`default_nettype wire

@@ rtl/velocity_curve_generator.sv @@
// Top level: request register, point sequencer and result register.
//
// Usage: a request item on the req_ channel gives a shape, a start and end
// marking and a span in ticks. The block answers with seventeen point items
// on the rsp_ channel, numbered 0 to 16, the last one flagged by last_point.
// Both channels move an item when valid is high and stall is low.
// The first point of a request is formed from the request register and
// shown from the result register. Points then follow one per cycle while
// rsp_stall is low; the point counter steps through them. The next
// request is taken in the same cycle as the last point of the current one
// is formed, so requests run back to back.
// While the receiver stalls, the shown point holds and the counter waits;
// req_stall stays high until the final point of the current request moves
// into the result register.
// Reset (synchronous, active high) drops any request in progress and
// clears the result valid.
`default_nettype none

module velocity_curve_generator
   import vcg_pkg::*;
(
   input  var logic    clock,
   input  var logic    reset,
   input  var logic    req_valid,
   output logic        req_stall,
   input  var req_type req_data,
   output logic        rsp_valid,
   input  var logic    rsp_stall,
   output rsp_type     rsp_data
);

   logic       busy_ff, busy_in;
   logic [4:0] index_ff, index_in;
   req_type    req_ff, req_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   rsp_type    point;
   logic       advance;
   logic       at_last;
   logic       req_take;

   // A point is formed when a request is held and the result register frees up.
   assign advance   = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign at_last   = (index_ff == LAST_POINT);
   assign req_stall = busy_ff && !(advance && at_last);
   assign req_take  = req_valid && !req_stall;

   vcg_point u_point (
      .req   (req_ff),
      .idx   (index_ff),
      .point (point)
   );

   // Next values for the sequencer and both registers.
   always_comb begin
      busy_in  = busy_ff;
      index_in = index_ff;
      req_in   = req_ff;
      priority if (req_take) begin
         busy_in  = 1'b1;
         index_in = 5'd0;
         req_in   = req_data;
      end else if (advance && at_last) begin
         busy_in  = 1'b0;
         index_in = 5'd0;
      end else if (advance) begin
         index_in = index_ff + 5'd1;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_in       = point;
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         index_ff     <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A taken point that is not the last is followed by the next one at once.
   a_next_point: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last_point) |=>
      (rsp_valid && rsp_data.point_number == $past(rsp_data.point_number) + 5'd1))
      else $error("point sequence broke");

   // A taken request always starts at point zero.
   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (busy_ff && index_ff == 5'd0))
      else $error("request did not start at point zero");

   // The last flag marks only the final point.
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_point == (rsp_data.point_number == LAST_POINT)))
      else $error("last flag on wrong point");

   // The counter rests at zero while no request is held.
   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (index_ff == 5'd0))
      else $error("counter moved while idle");

endmodule

`default_nettype wire

@@ bench/vcg_point_checker.sv @@
// Checker that predicts every curve point of the velocity curve generator and compares it.
module vcg_point_checker
   import vcg_pkg::*;
(
   input  var logic    clock,
   input  var logic    reset,
   input  var logic    req_valid,
   input  var logic    req_stall,
   input  var req_type req_data,
   input  var logic    rsp_valid,
   input  var logic    rsp_stall,
   input  var rsp_type rsp_data,
   output int          mismatch_count,
   output int          points_pending
);

   // Curve points still owed by the block, oldest first.
   rsp_type expected_points[$];
   int      fail_total = 0;

   // Velocity that stands for each dynamic marking.
   function automatic int marking_velocity(input logic [2:0] marking);
      int v;
      case (marking)
         3'd0: v = 16;
         3'd1: v = 33;
         3'd2: v = 49;
         3'd3: v = 64;
         3'd4: v = 80;
         3'd5: v = 96;
         3'd6: v = 112;
         default: v = 127;
      endcase
      return v;
   endfunction

   // Half sine in Q1.16, folded around the middle point.
   function automatic int half_sine(input int idx);
      int k;
      int s;
      k = (idx > 8) ? 16 - idx : idx;
      case (k)
         1: s = 12785;
         2: s = 25080;
         3: s = 36410;
         4: s = 46341;
         5: s = 54491;
         6: s = 60547;
         7: s = 64277;
         8: s = 65536;
         default: s = 0;
      endcase
      return s;
   endfunction

   // Marking band that a clamped velocity falls into.
   function automatic logic [2:0] marking_of(input int v);
      if (v < 25) return 3'd0;
      if (v < 41) return 3'd1;
      if (v < 57) return 3'd2;
      if (v < 72) return 3'd3;
      if (v < 88) return 3'd4;
      if (v < 104) return 3'd5;
      if (v < 120) return 3'd6;
      return 3'd7;
   endfunction

   // Work out all points of one request and queue them in order.
   function automatic void predict_curve(input req_type r);
      int         sv;
      int         ev;
      int         d;
      int         v;
      int         i;
      logic [23:0] step;
      rsp_type    p;
      sv   = marking_velocity(r.start_level);
      ev   = marking_velocity(r.end_level);
      d    = ev - sv;
      step = r.span_ticks >> 4;
      for (i = 0; i < POINT_COUNT; i++) begin
         v = sv;
         p = '0;
         p.point_note = NOTE_NONE;
         case (r.curve_shape)
            SHAPE_CRESC: begin
               v = sv + (i * d) / 16;
               if (i == 0) p.point_note = NOTE_CRESC;
            end
            SHAPE_DECRESC: begin
               v = sv - (i * (sv - ev)) / 16;
               if (i == 0) p.point_note = NOTE_DIM;
            end
            SHAPE_SWELL: begin
               if (i < 8) v = sv + (i * d) / 8;
               else v = ev - ((i - 8) * d) / 8;
            end
            SHAPE_HAIRPIN: begin
               v = sv + (half_sine(i) * d) / 65536;
            end
            SHAPE_SFZ: begin
               v = (i <= 1) ? 127 : sv;
               if (i == 0) p.point_note = NOTE_SFZ;
            end
            SHAPE_FORTEPIANO: begin
               v = (i <= 1) ? 96 : 49;
               if (i == 0) p.point_note = NOTE_FP;
            end
            SHAPE_TERRACED: begin
               v = sv + ((i / 4) * d) / 4;
            end
            SHAPE_SUBITO: begin
               v = (i < 8) ? sv : ev;
               if (i == 8) p.point_note = NOTE_SUBITO;
            end
            default: begin
               // Constant, and every code past the last shape behaves the same way.
               v = sv;
            end
         endcase
         if (v < 1) v = 1;
         if (v > 127) v = 127;
         p.point_number   = 5'(i);
         p.point_tick     = 24'(i * step);
         p.point_velocity = 7'(v);
         p.point_level    = marking_of(v);
         p.last_point     = (i == POINT_COUNT - 1);
         expected_points.insert(expected_points.size(), p);
      end
   endfunction

   // Report one field that differs from its prediction.
   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_total++;
      end
   endfunction

   // Compare each point taken by the receiver, then record each request taken by the block.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_points.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               $error("point %0d arrived while no point was expected", rsp_data.point_number);
               fail_total++;
            end else begin
               want = expected_points.pop_front();
               check_field("point_number", want.point_number, rsp_data.point_number);
               check_field("point_tick", want.point_tick, rsp_data.point_tick);
               check_field("point_velocity", want.point_velocity, rsp_data.point_velocity);
               check_field("point_level", want.point_level, rsp_data.point_level);
               check_field("point_note", want.point_note, rsp_data.point_note);
               check_field("last_point", want.last_point, rsp_data.last_point);
            end
         end
         if (req_valid && !req_stall) predict_curve(req_data);
      end
      mismatch_count <= fail_total;
      points_pending <= expected_points.size();
   end

endmodule

@@ bench/tb_velocity_curve_generator.sv @@
// Testbench top for the velocity curve generator: stimulus, receiver and verdict.
module tb_velocity_curve_generator;
   import vcg_pkg::*;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      mismatch_count;
   int      points_pending;

   // Sender runs without gaps while this is set.
   logic    sender_quiet  = 1'b0;
   // Asks the receiver for one long hold-off.
   logic    long_hold_due = 1'b0;

   always #6 clock = ~clock;

   velocity_curve_generator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   vcg_point_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .points_pending (points_pending)
   );

   // Offer one request after a random gap (none while sender_quiet) and hold it until the block takes it.
   task automatic offer_request(input req_type r);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering and wait until every predicted point has come out.
   task automatic drain_points();
      req_valid <= 1'b0;
      @(posedge clock);
      while (points_pending != 0) @(posedge clock);
   endtask

   // Mostly legal shapes; span near zero, near full scale or anywhere.
   function automatic req_type random_request();
      req_type r;
      if ($urandom_range(0, 9) == 0)
         r.curve_shape = 4'($urandom_range(int'(SHAPE_SUBITO) + 1, 15));
      else
         r.curve_shape = 4'($urandom_range(int'(SHAPE_CONSTANT), int'(SHAPE_SUBITO)));
      r.start_level = 3'($urandom_range(0, 7));
      r.end_level   = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
         0: r.span_ticks = 24'($urandom_range(0, 63));
         1: r.span_ticks = 24'hFFFFFF - 24'($urandom_range(0, 63));
         default: r.span_ticks = 24'($urandom);
      endcase
      return r;
   endfunction

   // Stimulus: directed requests, then random phases with one long hold and one drain.
   initial begin
      req_type r;
      int      s;
      int      n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Every shape rising over the whole range at full span, and falling with zero span.
      for (s = int'(SHAPE_CONSTANT); s <= int'(SHAPE_SUBITO); s++) begin
         r = '{4'(s), 3'd0, 3'd7, 24'hFFFFFF};
         offer_request(r);
         r = '{4'(s), 3'd7, 3'd0, 24'd0};
         offer_request(r);
      end
      // Unused shape codes, a span just below one tick step and exactly one step.
      r = '{4'hF, 3'd7, 3'd0, 24'd15};
      offer_request(r);
      r = '{4'(int'(SHAPE_SUBITO) + 1), 3'd2, 3'd5, 24'd16};
      offer_request(r);
      // Equal markings, and a mid-range hairpin.
      r = '{SHAPE_CRESC, 3'd3, 3'd3, 24'h123456};
      offer_request(r);
      r = '{SHAPE_HAIRPIN, 3'd2, 3'd6, 24'd1000};
      offer_request(r);
      drain_points();

      for (n = 0; n < 250; n++) begin
         if (n % 25 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
         if (n == 100) begin
            // Keep offering back to back while the receiver holds off.
            sender_quiet = 1'b1;
            long_hold_due <= 1'b1;
         end
         if (n == 175) drain_points();
         offer_request(random_request());
      end

      drain_points();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Receiver: random stall before each item, quiet stretches, and one long hold-off.
   initial begin
      int   gap;
      int   run;
      logic receiver_quiet;
      run = 0;
      receiver_quiet = 1'b0;
      forever begin
         if (long_hold_due) begin
            rsp_stall <= 1'b1;
            repeat (80) @(posedge clock);
            long_hold_due <= 1'b0;
         end
         if (run == 0) begin
            receiver_quiet = ($urandom_range(0, 3) == 0);
            run = 40;
         end
         run--;
         gap = receiver_quiet ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Run limit, well beyond the slowest correct run.
   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ files.f @@
rtl/vcg_pkg.sv
rtl/vcg_point.sv
rtl/velocity_curve_generator.sv
bench/vcg_point_checker.sv
bench/tb_velocity_curve_generator.sv
